// ===== design/stbs_pkg.sv =====
// shared types and constants of the sorted table binary search block
`timescale 1ns / 1ps
`default_nettype none

package stbs_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // fixed field widths
  localparam int POS_W  = 10;
  localparam int WORD_W = 32;

  // width that holds any position field, any table address and the depth itself
  localparam int EXT_W = ((ADDR_W > POS_W) ? ADDR_W : POS_W) + 1;

  // command codes
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [WORD_W-1:0] word_t;

  // one request
  typedef struct packed {
    logic                     command;
    logic [POS_W-1:0]         index;
    logic signed [WORD_W-1:0] value;
    logic [POS_W-1:0]         range_low;
    logic [POS_W-1:0]         range_high;
  } req_t;

  // one result
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } rsp_t;

endpackage

`default_nettype wire

// ===== design/stbs_ram.sv =====
// word table: one write port, one read port with registered read data
`timescale 1ns / 1ps
`default_nettype none

module stbs_ram (
  input  wire                  clk,
  input  wire                  we,
  input  wire stbs_pkg::addr_t waddr,
  input  wire stbs_pkg::word_t wdata,
  input  wire stbs_pkg::addr_t raddr,
  output stbs_pkg::word_t      rdata
);
  import stbs_pkg::*;

  word_t mem [TABLE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/sorted_table_binary_search.sv =====
// top level of the sorted table binary search block
`timescale 1ns / 1ps
`default_nettype none

// Holds a table of 1024 signed 32-bit words in one synchronous RAM and serves
// one request at a time. After reset the block runs a clearing pass that zeroes
// the table one word a cycle and stalls requests until it ends. A write request
// stores its word in the cycle it is accepted and posts its result from the
// finish state once the output slot is free. A search request is set up, then
// runs probes, each a RAM read and a compare in the next cycle, at most 11 for a
// full-table search (none for an empty range), then posts its result likewise.
// The registered RAM read is why each probe has its own compare state. The
// result sits in an output register, so a new request is taken while a result
// still waits to be taken downstream.

module sorted_table_binary_search (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 req_valid,
  output logic                req_stall,
  input  wire stbs_pkg::req_t req,
  output logic                rsp_valid,
  input  wire                 rsp_stall,
  output stbs_pkg::rsp_t      rsp
);
  import stbs_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_FINISH
  } state_t;

  state_t state;

  // search registers
  addr_t                    clr_idx;
  addr_t                    lo;
  addr_t                    hi;
  addr_t                    mid;
  logic signed [WORD_W-1:0] target;
  logic                     res_found;
  logic [POS_W-1:0]         res_pos;

  // ram ports
  logic  ram_we;
  addr_t ram_waddr;
  word_t ram_wdata;
  addr_t ram_raddr;
  word_t ram_rdata;

  // decoded request fields
  logic             accept;
  logic [EXT_W-1:0] idx_ext;
  logic [EXT_W-1:0] rlo_ext;
  logic [EXT_W-1:0] rhi_ext;
  logic [EXT_W-1:0] rhi_sat;
  logic             idx_ok;
  logic             range_empty;
  logic [ADDR_W:0]  mid_sum;
  addr_t            mid_calc;
  logic [EXT_W-1:0] mid_ext;
  logic signed [WORD_W-1:0] probe;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;

  // request decode and range saturation
  always_comb begin
    idx_ext     = EXT_W'(req.index);
    rlo_ext     = EXT_W'(req.range_low);
    rhi_ext     = EXT_W'(req.range_high);
    rhi_sat     = (rhi_ext > EXT_W'(TABLE_DEPTH - 1)) ? EXT_W'(TABLE_DEPTH - 1) : rhi_ext;
    idx_ok      = idx_ext < EXT_W'(TABLE_DEPTH);
    range_empty = rlo_ext > rhi_sat;
  end

  // midpoint of the live range, rounded down
  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid_calc = mid_sum[ADDR_W:1];
  assign mid_ext  = EXT_W'(mid);
  assign probe    = $signed(ram_rdata);

  // ram write: clearing pass or accepted write request
  always_comb begin
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx;
      ram_wdata = '0;
    end else begin
      ram_we    = accept && (req.command == CMD_WRITE) && idx_ok;
      ram_waddr = idx_ext[ADDR_W-1:0];
      ram_wdata = word_t'(req.value);
    end
  end

  assign ram_raddr = mid_calc;

  stbs_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // the finish state decides the slot itself
      if (rsp_valid && !rsp_stall && state != ST_FINISH) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (clr_idx == addr_t'(TABLE_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
          clr_idx <= clr_idx + addr_t'(1);
        end
        ST_IDLE: begin
          if (accept) begin
            target    <= req.value;
            lo        <= rlo_ext[ADDR_W-1:0];
            hi        <= rhi_sat[ADDR_W-1:0];
            res_found <= 1'b0;
            res_pos   <= '0;
            if (req.command == CMD_SEARCH && !range_empty) begin
              state <= ST_READ;
            end else begin
              state <= ST_FINISH;
            end
          end
        end
        ST_READ: begin
          mid   <= mid_calc;
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (probe == target) begin
            res_found <= 1'b1;
            res_pos   <= mid_ext[POS_W-1:0];
            state     <= ST_FINISH;
          end else if (probe < target) begin
            // go right, range empties when the midpoint was the top
            if (mid == hi) begin
              state <= ST_FINISH;
            end else begin
              lo    <= mid + addr_t'(1);
              state <= ST_READ;
            end
          end else begin
            // go left, range empties when the midpoint was the bottom
            if (mid == lo) begin
              state <= ST_FINISH;
            end else begin
              hi    <= mid - addr_t'(1);
              state <= ST_READ;
            end
          end
        end
        ST_FINISH: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid    <= 1'b1;
            rsp.found    <= res_found;
            rsp.position <= res_pos;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // one request in flight: an accepted request stalls the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> req_stall)
    else $error("request accepted while another is in flight");

  // a miss always reports position zero
  a_miss_pos_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.found) |-> (rsp.position == '0))
    else $error("not-found result with nonzero position");

  // the probed midpoint lies inside the live range
  a_mid_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP) |-> (lo <= mid && mid <= hi))
    else $error("probe outside search range");

  // a new result is loaded only when the output slot is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall && state == ST_FINISH) |=> (state == ST_FINISH))
    else $error("result posted while output slot is occupied");

  // no request is taken during the clearing pass
  a_clear_stalls: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (req_stall && !rsp_valid))
    else $error("activity during clearing pass");

endmodule

`default_nettype wire

// ===== verif/sorted_table_binary_search_test.sv =====
// self-checking testbench for the sorted table binary search block
`timescale 1ns / 1ps

module sorted_table_binary_search_test;
  import stbs_pkg::*;

  localparam int TOTAL_REQUESTS = 700;
  localparam int QUIET_FIRST    = 250;
  localparam int QUIET_LAST     = 400;
  localparam int IDLE_PERCENT   = 9;
  localparam int WATCHDOG_LIMIT = 4096;
  localparam int TAIL_CYCLES    = 40;
  localparam int MAX_REPORTS    = 10;

  // one request waiting for the driver; hold_off makes the driver wait for all results
  typedef struct {
    req_t item;
    bit   hold_off;
  } queued_request_t;

  logic clk;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  queued_request_t request_backlog[$];
  rsp_t            expected_results[$];
  logic signed [WORD_W-1:0] word_image [TABLE_DEPTH];

  int sent_count   = 0;
  int error_count  = 0;
  int stuck_cycles = 0;

  sorted_table_binary_search DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // expected result of one request, applied to the image of the table
  function automatic rsp_t bisect_expected(req_t r);
    rsp_t res;
    int lo;
    int hi;
    int mid;
    logic signed [WORD_W-1:0] probe;
    res = '0;
    if (r.command == CMD_WRITE) begin
      if (r.index < TABLE_DEPTH) word_image[r.index] = r.value;
    end else begin
      lo = int'(r.range_low);
      hi = (r.range_high > TABLE_DEPTH - 1) ? TABLE_DEPTH - 1 : int'(r.range_high);
      while (hi >= lo && !res.found) begin
        mid   = (lo + hi) / 2;
        probe = word_image[mid];
        if (probe == $signed(r.value)) begin
          res.found    = 1'b1;
          res.position = POS_W'(mid);
        end else if (probe < $signed(r.value)) begin
          lo = mid + 1;
        end else begin
          hi = mid - 1;
        end
      end
    end
    return res;
  endfunction

  function automatic req_t write_req(int idx, logic [WORD_W-1:0] val);
    req_t r;
    r.command    = CMD_WRITE;
    r.index      = POS_W'(idx);
    r.value      = val;
    r.range_low  = POS_W'($urandom);
    r.range_high = POS_W'($urandom);
    return r;
  endfunction

  function automatic req_t search_req(logic [WORD_W-1:0] val, int lo, int hi);
    req_t r;
    r.command    = CMD_SEARCH;
    r.index      = POS_W'($urandom);
    r.value      = val;
    r.range_low  = POS_W'(lo);
    r.range_high = POS_W'(hi);
    return r;
  endfunction

  function automatic void queue_request(req_t r, bit hold_off);
    queued_request_t q;
    q.item     = r;
    q.hold_off = hold_off;
    request_backlog.push_back(q);
  endfunction

  function automatic bit quiet_stretch();
    return sent_count >= QUIET_FIRST && sent_count < QUIET_LAST;
  endfunction

  task automatic flag_error(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR: %s", msg);
  endtask

  // request driver
  always @(posedge clk) begin : driver
    req_t next_req;
    logic next_valid;
    bit   took;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      took = req_valid && !req_stall;
      if (took) begin
        expected_results.push_back(bisect_expected(req));
        sent_count++;
      end
      next_valid = req_valid && !took;
      next_req   = req;
      if (!next_valid && request_backlog.size() != 0) begin
        if (request_backlog[0].hold_off && expected_results.size() != 0) begin
          // wait for the block to drain
        end else if (!quiet_stretch() && $urandom_range(99) < IDLE_PERCENT) begin
          // random gap
        end else begin
          next_req   = request_backlog[0].item;
          next_valid = 1'b1;
          void'(request_backlog.pop_front());
        end
      end
      req_valid <= next_valid;
      req       <= next_req;
    end
  end

  // result monitor and downstream stall
  always @(posedge clk) begin : monitor
    rsp_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_results.size() == 0) begin
          flag_error($sformatf("unexpected result found=%0d position=%0d",
                               rsp.found, rsp.position));
        end else begin
          want = expected_results.pop_front();
          if (rsp.found !== want.found || rsp.position !== want.position)
            flag_error($sformatf(
                "result mismatch: expected found=%0d position=%0d, got found=%0d position=%0d",
                want.found, want.position, rsp.found, rsp.position));
        end
      end
      rsp_stall <= !quiet_stretch() && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  // cycles without any handshake
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
  end

  initial begin : stimulus
    int vals[$];
    int order[$];
    int n;
    int m;
    int base;
    int lo;
    int hi;
    int pick;
    int kind;
    int target;
    bit narrow;

    foreach (word_image[i]) word_image[i] = '0;

    // directed: zeroed table, extremes, empty ranges, unsorted contents
    queue_request(search_req(32'h0000_0000, 0, 1023), 1'b0);
    queue_request(search_req(32'h7fff_ffff, 0, 1023), 1'b0);
    queue_request(search_req(32'h0000_0000, 5, 3), 1'b0);
    queue_request(search_req(32'h0000_0000, 1023, 0), 1'b0);
    queue_request(write_req(0, 32'h8000_0000), 1'b0);
    queue_request(write_req(1023, 32'h7fff_ffff), 1'b0);
    queue_request(search_req(32'h8000_0000, 0, 1023), 1'b0);
    queue_request(search_req(32'h7fff_ffff, 0, 1023), 1'b0);
    queue_request(search_req(32'h0000_0000, 1023, 1023), 1'b0);
    queue_request(search_req(32'h0000_0000, 0, 0), 1'b0);
    queue_request(search_req(32'hffff_ffff, 0, 1023), 1'b0);
    // sender pauses here until every earlier result has come back
    queue_request(write_req(511, 32'd100), 1'b1);
    queue_request(search_req(32'h0000_0000, 0, 1023), 1'b0);
    queue_request(search_req(32'd100, 511, 511), 1'b0);
    queue_request(search_req(32'd100, 0, 1023), 1'b0);
    queue_request(write_req(1023, 32'hffff_ffff), 1'b0);
    queue_request(search_req(32'hffff_ffff, 1000, 1023), 1'b0);
    queue_request(write_req(1023, 32'h0000_0000), 1'b0);
    queue_request(search_req(32'h0000_0000, 1023, 1023), 1'b0);
    queue_request(write_req(0, 32'h0000_0000), 1'b0);
    queue_request(search_req(32'h8000_0000, 0, 1023), 1'b0);

    // random: mostly sorted runs followed by searches, the rest noise
    while (request_backlog.size() < TOTAL_REQUESTS) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        n      = ($urandom_range(7) == 0) ? $urandom_range(41, 160) : $urandom_range(1, 40);
        base   = $urandom_range(0, TABLE_DEPTH - n);
        narrow = ($urandom_range(2) == 0);
        vals.delete();
        order.delete();
        for (int i = 0; i < n; i++) begin
          if (i > 0 && $urandom_range(4) == 0) vals.push_back(vals[i-1]);
          else if (narrow) vals.push_back(int'($urandom_range(40)) - 20);
          else vals.push_back($urandom);
          order.push_back(i);
        end
        vals.sort();
        order.shuffle();
        for (int k = 0; k < n; k++)
          queue_request(write_req(base + order[k], vals[order[k]]),
                        k == 0 && $urandom_range(9) == 0);
        m = $urandom_range(3, 10);
        for (int j = 0; j < m; j++) begin
          pick = $urandom_range(n - 1);
          case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: target = vals[pick];
            6:                target = vals[pick] + 1;
            7:                target = vals[pick] - 1;
            default:          target = $urandom;
          endcase
          case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: begin
              lo = base;
              hi = base + n - 1;
            end
            6, 7: begin
              lo = base + $urandom_range(n - 1);
              hi = lo + $urandom_range(base + n - 1 - lo);
            end
            8: begin
              lo = $urandom_range(base);
              hi = $urandom_range(base + n - 1, TABLE_DEPTH - 1);
            end
            default: begin
              // empty range
              lo = $urandom_range(1, TABLE_DEPTH - 1);
              hi = $urandom_range(lo - 1);
            end
          endcase
          queue_request(search_req(target, lo, hi), 1'b0);
        end
      end else if (kind < 85) begin
        queue_request(write_req($urandom_range(TABLE_DEPTH - 1), $urandom), 1'b0);
      end else if (kind < 95) begin
        queue_request(search_req($urandom, $urandom, $urandom), 1'b0);
      end else begin
        queue_request(search_req($urandom, 0, TABLE_DEPTH - 1), 1'b0);
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // wait for every request to be taken and every result to come back
    while ((request_backlog.size() != 0 || req_valid || expected_results.size() != 0)
           && stuck_cycles < WATCHDOG_LIMIT)
      @(posedge clk);

    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
    end else begin
      repeat (TAIL_CYCLES) @(posedge clk);
      if (expected_results.size() != 0)
        flag_error($sformatf("%0d results never arrived", expected_results.size()));
      if (error_count == 0) begin
        $display("ALL CHECKS PASSED");
      end else begin
        $display("CHECKS FAILED");
      end
    end
    $finish;
  end

endmodule
